FILE: rtl/core/tbd_pkg.sv
// Shared types and constants for the tape block deframer.
`default_nettype none
package tbd_pkg;
   localparam logic [7:0] SYNC_BYTE    = 8'h2A;
   localparam int         MAX_NAME_LEN = 10;
   localparam int         NAME_W       = $clog2(MAX_NAME_LEN + 1);
   localparam logic [4:0] HDR_BYTES    = 5'd17;

   localparam logic [1:0] KIND_NAME    = 2'd0;
   localparam logic [1:0] KIND_DATA    = 2'd1;
   localparam logic [1:0] KIND_SUMMARY = 2'd2;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD_SYNC  = 3'd1;
   localparam logic [2:0] ST_NAME_LONG = 3'd2;
   localparam logic [2:0] ST_HDR_CRC   = 3'd3;
   localparam logic [2:0] ST_DATA_CRC  = 3'd4;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  byte_out;
      logic [15:0] load_addr;
      logic [15:0] exec_addr;
      logic [15:0] block_num;
      logic [15:0] payload_len;
      logic [7:0]  flag_bits;
      logic [31:0] next_file_word;
      logic [2:0]  status;
      logic [16:0] total_size;
      logic        last;
   } rsp_type;

   // CRC-16/XMODEM over one byte, MSB first
   function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
      end
      return c;
   endfunction
endpackage
`default_nettype wire

FILE: rtl/core/tbd_front.sv
// Front end: parses the byte stream and forms result transactions.
`default_nettype none
module tbd_front import tbd_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_take,
   input  wire logic [7:0] in_byte,
   output rsp_type      out_item,
   output logic         out_push
);
   localparam logic [2:0] PH_SYNC = 3'd0;
   localparam logic [2:0] PH_NAME = 3'd1;
   localparam logic [2:0] PH_HDR  = 3'd2;
   localparam logic [2:0] PH_HCRC = 3'd3;
   localparam logic [2:0] PH_DATA = 3'd4;
   localparam logic [2:0] PH_DCRC = 3'd5;

   logic [2:0]  phase_ff, phase_in;
   logic [15:0] count_ff, count_in;
   logic [NAME_W-1:0] name_ff, name_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  hi_ff, hi_in;
   logic [15:0] load_ff, load_in, exec_ff, exec_in, blk_ff, blk_in, len_ff, len_in;
   logic [7:0]  flags_ff, flags_in;
   logic [31:0] next_ff, next_in;
   logic [16:0] total_ff, total_in;
   logic [15:0] crc_next, rx_crc, count_inc;
   logic [16:0] total_inc;
   logic        summ;
   logic [2:0]  st;

   assign crc_next  = crc_update(crc_ff, in_byte);
   assign rx_crc    = {hi_ff, in_byte};
   assign count_inc = count_ff + 16'd1;
   assign total_inc = total_ff + 17'd1;

   // Phase sequencing, header latching, CRC checks and result forming
   always_comb begin
      phase_in = phase_ff; count_in = count_ff; name_in = name_ff; crc_in = crc_ff;
      hi_in = hi_ff; load_in = load_ff; exec_in = exec_ff; blk_in = blk_ff;
      len_in = len_ff; flags_in = flags_ff; next_in = next_ff; total_in = total_ff;
      summ = 1'b0; st = ST_OK;
      out_push = 1'b0;
      out_item = '0;
      if (in_take) begin
         total_in = total_inc;
         unique case (phase_ff)
            PH_SYNC: begin
               if (in_byte != SYNC_BYTE) begin
                  summ = 1'b1; st = ST_BAD_SYNC;
               end else begin
                  phase_in = PH_NAME;
               end
            end
            PH_NAME: begin
               if (in_byte == 8'd0) begin
                  crc_in = crc_next; phase_in = PH_HDR; count_in = '0;
               end else if (name_ff >= NAME_W'(MAX_NAME_LEN)) begin
                  summ = 1'b1; st = ST_NAME_LONG;
               end else begin
                  crc_in = crc_next; name_in = name_ff + 1'b1;
                  out_push = 1'b1; out_item.kind = KIND_NAME; out_item.byte_out = in_byte;
               end
            end
            PH_HDR: begin
               crc_in = crc_next;
               case (count_ff[4:0])
                  5'd0:  load_in[7:0]   = in_byte;
                  5'd1:  load_in[15:8]  = in_byte;
                  5'd4:  exec_in[7:0]   = in_byte;
                  5'd5:  exec_in[15:8]  = in_byte;
                  5'd8:  blk_in[7:0]    = in_byte;
                  5'd9:  blk_in[15:8]   = in_byte;
                  5'd10: len_in[7:0]    = in_byte;
                  5'd11: len_in[15:8]   = in_byte;
                  5'd12: flags_in       = in_byte;
                  5'd13: next_in[7:0]   = in_byte;
                  5'd14: next_in[15:8]  = in_byte;
                  5'd15: next_in[23:16] = in_byte;
                  5'd16: next_in[31:24] = in_byte;
                  default: ;
               endcase
               count_in = count_inc;
               if (count_inc[4:0] >= HDR_BYTES) begin
                  phase_in = PH_HCRC; count_in = '0;
               end
            end
            PH_HCRC: begin
               hi_in = in_byte; count_in = count_inc;
               if (count_ff != 16'd0) begin
                  if (rx_crc != crc_ff) begin
                     summ = 1'b1; st = ST_HDR_CRC;
                  end else begin
                     crc_in = '0; count_in = '0;
                     phase_in = (len_ff == 16'd0) ? PH_DCRC : PH_DATA;
                  end
               end
            end
            PH_DATA: begin
               crc_in = crc_next; count_in = count_inc;
               out_push = 1'b1; out_item.kind = KIND_DATA; out_item.byte_out = in_byte;
               if (count_inc >= len_ff) begin
                  count_in = '0; phase_in = PH_DCRC;
               end
            end
            PH_DCRC: begin
               hi_in = in_byte; count_in = count_inc;
               if (count_ff != 16'd0) begin
                  summ = 1'b1; st = (rx_crc == crc_ff) ? ST_OK : ST_DATA_CRC;
               end
            end
            default: begin
               phase_in = PH_SYNC;
            end
         endcase
         if (summ) begin
            out_push = 1'b1;
            out_item.kind = KIND_SUMMARY;
            out_item.load_addr = load_ff; out_item.exec_addr = exec_ff;
            out_item.block_num = blk_ff;  out_item.payload_len = len_ff;
            out_item.flag_bits = flags_ff; out_item.next_file_word = next_ff;
            out_item.status = st; out_item.total_size = total_inc; out_item.last = 1'b1;
            phase_in = PH_SYNC; count_in = '0; name_in = '0; crc_in = '0; hi_in = '0;
            load_in = '0; exec_in = '0; blk_in = '0; len_in = '0; flags_in = '0;
            next_in = '0; total_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SYNC; count_ff <= '0; name_ff <= '0; crc_ff <= '0; hi_ff <= '0;
         load_ff <= '0; exec_ff <= '0; blk_ff <= '0; len_ff <= '0; flags_ff <= '0;
         next_ff <= '0; total_ff <= '0;
      end else begin
         phase_ff <= phase_in; count_ff <= count_in; name_ff <= name_in; crc_ff <= crc_in;
         hi_ff <= hi_in; load_ff <= load_in; exec_ff <= exec_in; blk_ff <= blk_in;
         len_ff <= len_in; flags_ff <= flags_in; next_ff <= next_in; total_ff <= total_in;
      end
   end

`ifndef ASSERT_OFF
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= PH_DCRC) else $error("phase out of range");
   a_name_bound: assert property (@(posedge clock) disable iff (reset)
      name_ff <= NAME_W'(MAX_NAME_LEN)) else $error("name length overflow");
   a_summary_clears: assert property (@(posedge clock) disable iff (reset)
      (out_push && out_item.last) |=> (phase_ff == PH_SYNC && total_ff == '0))
      else $error("state not cleared after summary");
`endif
endmodule
`default_nettype wire

FILE: rtl/core/tbd_back.sv
// Back end: result queue that drives the response channel.
`default_nettype none
module tbd_back import tbd_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  rsp_type   push_item,
   input  wire logic push,
   output logic      full,
   output rsp_type   head,
   output logic      head_valid,
   input  wire logic pop
);
   rsp_type     mem_ff [QUEUE_DEPTH];
   logic        wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        do_pop;

   assign head_valid = cnt_ff != 2'd0;
   assign full       = cnt_ff == 2'(QUEUE_DEPTH);
   assign head       = mem_ff[rp_ff];
   assign do_pop     = pop && head_valid;

   // Pointer and count update
   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = do_pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= push_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !do_pop)) else $error("queue overflow");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'(QUEUE_DEPTH)) else $error("queue count out of range");
   a_head_hold: assert property (@(posedge clock) disable iff (reset)
      (head_valid && !pop) |=> (head_valid && $stable(head)))
      else $error("stalled head changed");
`endif
endmodule
`default_nettype wire

FILE: rtl/core/tape_block_deframer_crc16.sv
// Top level of the tape block deframer with CRC-16 header and data checks.
// Input channel req_: one raw tape byte per transaction (req_byte_in).
// Result channel rsp_: name bytes (kind 0), data bytes (kind 1) and one
// block summary (kind 2, last high) with header fields, status and size.
// Each input byte yields zero or one result; a result enters the result
// queue and appears on rsp_ once the results ahead of it have left.
// Throughput is one byte per cycle while req_stall is low, bounded by the
// CRC byte update in the parser. A two-entry result queue separates parser
// and output so the parser keeps taking bytes while a result waits.
// req_stall rises only when the queue is full and nothing leaves it.
// Synchronous active-high reset returns the parser to the sync wait with
// all header fields zero and empties the queue.
// When the receiver holds rsp_stall, the head result stays unchanged.
`default_nettype none
module tape_block_deframer_crc16 import tbd_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_byte_in,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_kind,
   output logic [7:0]       rsp_byte_out,
   output logic [15:0]      rsp_load_addr,
   output logic [15:0]      rsp_exec_addr,
   output logic [15:0]      rsp_block_num,
   output logic [15:0]      rsp_payload_len,
   output logic [7:0]       rsp_flag_bits,
   output logic [31:0]      rsp_next_file_word,
   output logic [2:0]       rsp_status,
   output logic [16:0]      rsp_total_size,
   output logic             rsp_last
);
   rsp_type item, head;
   logic    push, full, take, pop;

   assign pop       = !rsp_stall;
   assign req_stall = full && rsp_stall;
   assign take      = req_valid && !req_stall;

   tbd_front u_front (
      .clock(clock), .reset(reset), .in_take(take), .in_byte(req_byte_in),
      .out_item(item), .out_push(push)
   );

   tbd_back u_back (
      .clock(clock), .reset(reset), .push_item(item), .push(push), .full(full),
      .head(head), .head_valid(rsp_valid), .pop(pop)
   );

   assign rsp_kind           = head.kind;
   assign rsp_byte_out       = head.byte_out;
   assign rsp_load_addr      = head.load_addr;
   assign rsp_exec_addr      = head.exec_addr;
   assign rsp_block_num      = head.block_num;
   assign rsp_payload_len    = head.payload_len;
   assign rsp_flag_bits      = head.flag_bits;
   assign rsp_next_file_word = head.next_file_word;
   assign rsp_status         = head.status;
   assign rsp_total_size     = head.total_size;
   assign rsp_last           = head.last;

`ifndef ASSERT_OFF
   a_last_is_summary: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_kind == KIND_SUMMARY))) else $error("last mismatch");
   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kind != 2'd3)) else $error("bad kind");
   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid) else $error("stall with empty queue");
`endif
endmodule
`default_nettype wire
